### rtl/core/hmf_pkg.sv
// Shared types, register indexes and the exp(-k/16) lookup table of the filter mask.
package hmf_pkg;

  typedef enum logic [2:0] {
    CfgGainHigh = 3'd0,
    CfgGainLow  = 3'd1,
    CfgSharp    = 3'd2,
    CfgCutoff   = 3'd3,
    CfgRowCount = 3'd4,
    CfgColCount = 3'd5
  } cfg_idx_e;

  // control that travels alongside the payload
  typedef struct packed {
    logic valid;
    logic sat;
  } hmf_ctrl_t;

  localparam int unsigned ExpSteps = 256;
  localparam logic [63:0] ExpRatioQ30 = 64'd1008687096;

  typedef logic [16:0] exp_tab_t [0:ExpSteps];

  // Q16 samples of exp(-k/16), from a Q30 geometric recurrence
  function automatic exp_tab_t build_exp_tab();
    logic [63:0] e;
    exp_tab_t    t;
    e = 64'd1 << 30;
    for (int k = 0; k <= ExpSteps; k++) begin
      t[k] = 17'((e + (64'd1 << 13)) >> 14);
      e    = (e * ExpRatioQ30 + (64'd1 << 29)) >> 30;
    end
    return t;
  endfunction

  localparam exp_tab_t ExpTab = build_exp_tab();

endpackage

### rtl/core/homomorphic_filter_mask.sv
// Top level: Gaussian high-emphasis homomorphic filter gain, one coordinate per cycle.
//
//   channel   direction  signals                                  handshake
//   command   in         start_i, row_index_i, col_index_i, busy_o  start_i && !busy_o
//   result    out        done_o, filter_gain_o                    one-cycle strobe
//   config    in         cfg_we_i, cfg_addr_i, cfg_wdata_i          write on cfg_we_i
//
// Throughput is one item per clock; busy_o never rises. The pipe has 26 register
// stages, the first loaded at the accepting edge and the last driving done_o; most
// of it is the 16-stage bit-per-stage divider that forms c*D2*4096/d0^2. Reset
// (rst_ni, async, low) clears the valid bits and loads the register defaults.
// The receiver cannot stall, so results simply leave the last stage as they
// arrive.
module homomorphic_filter_mask
  import hmf_pkg::*;
#(
  parameter int MAX_DIM = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [9:0]  row_index_i,
  input  logic [9:0]  col_index_i,
  output logic        done_o,
  output logic [14:0] filter_gain_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [10:0] cfg_wdata_i
);

  localparam logic [12:0] MaxDimW  = 13'(MAX_DIM);
  localparam logic [10:0] MaxDimS  = 11'(MAX_DIM);
  // ceil(2^20 / 5), exact for quotients of values below 2^18
  localparam logic [17:0] RecipFive = 18'd209716;

  // ---------------- configuration registers ----------------
  logic [5:0]  gain_high_q;
  logic [3:0]  gain_low_q;
  logic [6:0]  sharp_q;
  logic [7:0]  cutoff_q;
  logic [10:0] row_count_q, col_count_q;
  logic [15:0] den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_high_q <= '0;
      gain_low_q  <= '0;
      sharp_q     <= 7'd1;
      cutoff_q    <= 8'd1;
      row_count_q <= 11'd1024;
      col_count_q <= 11'd1024;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CfgGainHigh: gain_high_q <= cfg_wdata_i[5:0];
        CfgGainLow:  gain_low_q  <= cfg_wdata_i[3:0];
        CfgSharp:    sharp_q     <= cfg_wdata_i[6:0];
        CfgCutoff:   cutoff_q    <= cfg_wdata_i[7:0];
        CfgRowCount: row_count_q <= cfg_wdata_i;
        CfgColCount: col_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // zero sharpness / cutoff behave as one
  logic [6:0] c_eff;
  logic [7:0] d0_eff;
  assign c_eff  = (sharp_q == '0) ? 7'd1 : sharp_q;
  assign d0_eff = (cutoff_q == '0) ? 8'd1 : cutoff_q;

  // d0^2 registered off datapath; user holds it static for items in flight, unenforced
  always_ff @(posedge clk_i) begin
    den_q <= 16'(d0_eff) * 16'(d0_eff);
  end

  // plane centre, sizes saturated at MAX_DIM
  logic [10:0] row_sz, col_sz;
  logic [9:0]  row_ctr, col_ctr;
  assign row_sz  = ({2'b0, row_count_q} > MaxDimW) ? MaxDimS : row_count_q;
  assign col_sz  = ({2'b0, col_count_q} > MaxDimW) ? MaxDimS : col_count_q;
  assign row_ctr = row_sz[10:1];
  assign col_ctr = col_sz[10:1];

  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // ---------------- stage 1: distances ----------------
  logic       v1_q;
  logic [9:0] dr_q, dc_q, dr_d, dc_d;
  assign dr_d = (row_index_i >= row_ctr) ? (row_index_i - row_ctr) : (row_ctr - row_index_i);
  assign dc_d = (col_index_i >= col_ctr) ? (col_index_i - col_ctr) : (col_ctr - col_index_i);

  // ---------------- stage 2: squares ----------------
  logic        v2_q;
  logic [19:0] sr_q, sc_q;

  // ---------------- stage 3: D2 ----------------
  logic        v3_q;
  logic [20:0] d2_q;

  // ---------------- stage 4: c * D2 ----------------
  logic        v4_q;
  logic [27:0] prod_q;

  // ---------------- stage 5: dividend and saturation ----------------
  logic [40:0] numer;
  logic        sat_d;
  hmf_ctrl_t   ctrl5_q;
  logic [31:0] rem5_q;
  assign numer = {1'b0, prod_q, 12'b0} + 41'(den_q >> 1);
  assign sat_d = numer >= {9'b0, den_q, 16'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      ctrl5_q <= '0;
    end else begin
      v1_q          <= accept;
      v2_q          <= v1_q;
      v3_q          <= v2_q;
      v4_q          <= v3_q;
      ctrl5_q.valid <= v4_q;
      ctrl5_q.sat   <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dr_q   <= dr_d;
    dc_q   <= dc_d;
    sr_q   <= 20'(dr_q) * 20'(dr_q);
    sc_q   <= 20'(dc_q) * 20'(dc_q);
    d2_q   <= 21'(sr_q) + 21'(sc_q);
    prod_q <= 28'(c_eff) * 28'(d2_q);
    rem5_q <= numer[31:0];
  end

  // ---------------- stages 6..21: x = round(c*D2*4096 / d0^2) ----------------
  logic [15:0] x_w;
  hmf_ctrl_t   ctrl_div;

  hmf_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .den_i  (den_q),
    .rem_i  (rem5_q),
    .ctrl_i (ctrl5_q),
    .x_o    (x_w),
    .ctrl_o (ctrl_div)
  );

  // ---------------- stage 22: table lookup ----------------
  logic [8:0]  tk;
  logic [16:0] ta, tb;
  logic        va_q, sata_q;
  logic [16:0] a_q, diff_q;
  logic [7:0]  f_q;
  assign tk = {1'b0, x_w[15:8]};
  assign ta = ExpTab[tk];
  assign tb = ExpTab[tk + 9'd1];

  // ---------------- stage 23: interpolated exp(-x) ----------------
  logic        vb_q;
  logic [24:0] corr;
  logic [16:0] ex_q;
  assign corr = (25'(diff_q) * 25'(f_q) + 25'd128) >> 8;

  // ---------------- stage 24: num = gL*65536 + (gH-gL)*(65536-E) ----------------
  logic               vc_q;
  logic [16:0]        term;
  logic signed [6:0]  gdiff;
  logic signed [25:0] num_s;
  logic [21:0]        num_q;
  assign term  = 17'd65536 - ex_q;
  assign gdiff = $signed({1'b0, gain_high_q}) - $signed({3'b0, gain_low_q});
  assign num_s = $signed({6'b0, gain_low_q, 16'b0})
               + 26'(gdiff * $signed({1'b0, term}));

  // ---------------- stage 25/26: (num + 80) / 160 ----------------
  logic        vd_q;
  logic [16:0] v5_q;
  logic [22:0] num_r;
  logic [34:0] quo;
  assign num_r = 23'(num_q) + 23'd80;
  assign quo   = 35'(v5_q) * 35'(RecipFive);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q   <= 1'b0;
      vb_q   <= 1'b0;
      vc_q   <= 1'b0;
      vd_q   <= 1'b0;
      done_o <= 1'b0;
    end else begin
      va_q   <= ctrl_div.valid;
      vb_q   <= va_q;
      vc_q   <= vb_q;
      vd_q   <= vc_q;
      done_o <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sata_q        <= ctrl_div.sat;
    a_q           <= ctrl_div.sat ? '0 : ta;
    diff_q        <= ctrl_div.sat ? '0 : (ta - tb);
    f_q           <= x_w[7:0];
    ex_q          <= a_q - corr[16:0];
    num_q         <= num_s[25] ? '0 : num_s[21:0];
    v5_q          <= num_r[21:5];
    filter_gain_o <= quo[34:20];
  end

  // saturated argument gives exp term zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (va_q && sata_q) |=> (ex_q == '0))
    else $error("saturated exp term not zero");

  // exp term never exceeds one in Q16
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q |-> (ex_q <= 17'd65536))
    else $error("exp term above one");

  // blended gain bounded by the largest gain the registers can hold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q |-> (num_q <= 22'(63 * 65536)))
    else $error("gain numerator out of range");

endmodule

### rtl/core/hmf_divider.sv
// Sixteen-stage restoring divider: one quotient bit per pipeline stage.
module hmf_divider
  import hmf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] den_i,
  input  logic [31:0] rem_i,
  input  hmf_ctrl_t   ctrl_i,
  output logic [15:0] x_o,
  output hmf_ctrl_t   ctrl_o
);

  logic [31:0] rem_w  [17];
  logic [15:0] q_w    [17];
  hmf_ctrl_t   ctrl_w [17];

  assign rem_w[0]  = rem_i;
  assign q_w[0]    = '0;
  assign ctrl_w[0] = ctrl_i;

  for (genvar j = 0; j < 16; j++) begin : g_stage
    localparam int B = 15 - j;
    logic [31:0] shifted;
    logic        ge;
    logic [31:0] rem_d, rem_q;
    logic [15:0] q_d, q_q;
    hmf_ctrl_t   ctrl_q;

    assign shifted = 32'(den_i) << B;
    assign ge      = rem_w[j] >= shifted;
    assign rem_d   = ge ? (rem_w[j] - shifted) : rem_w[j];
    assign q_d     = q_w[j] | (16'(ge) << B);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctrl_q <= '0;
      end else begin
        ctrl_q <= ctrl_w[j];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q <= rem_d;
      q_q   <= q_d;
    end

    assign rem_w[j+1]  = rem_q;
    assign q_w[j+1]    = q_q;
    assign ctrl_w[j+1] = ctrl_q;
  end

  assign x_o    = q_w[16];
  assign ctrl_o = ctrl_w[16];

  // final remainder is reduced below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.valid && !ctrl_o.sat) |-> (rem_w[16] < 32'(den_i)))
    else $error("divider remainder not reduced");

  // first stage keeps the top quotient bit in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_w[1].valid && !ctrl_w[1].sat) |-> (rem_w[1] < (32'(den_i) << 15)))
    else $error("divider first stage out of range");

  // an entering item shows up in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.valid |=> ctrl_w[1].valid)
    else $error("divider dropped an item");

endmodule
